// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

// ===== hdl/rn2b_pkg.sv =====
// ----------------------------------------------------------------------------
// rn2b_pkg
// Symbol codes, error codes and helper functions of the Roman numeral decoder.
// ----------------------------------------------------------------------------
package rn2b_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 16;
  localparam int ERR_W   = 3;
  localparam int SYM_W   = 3;
  localparam int SVAL_W  = 10;
  localparam int RUN_W   = 3;

  localparam logic [VALUE_W-1:0] TOTAL_MAX = {VALUE_W{1'b1}};
  localparam logic [RUN_W-1:0]   RUN_INIT  = RUN_W'(1);
  localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};
  localparam logic [RUN_W-1:0]   RUN_LIMIT = RUN_W'(3);

  // Symbol codes, ordered by value.
  localparam logic [SYM_W-1:0] SYM_I = 3'd0;
  localparam logic [SYM_W-1:0] SYM_V = 3'd1;
  localparam logic [SYM_W-1:0] SYM_X = 3'd2;
  localparam logic [SYM_W-1:0] SYM_L = 3'd3;
  localparam logic [SYM_W-1:0] SYM_C = 3'd4;
  localparam logic [SYM_W-1:0] SYM_D = 3'd5;
  localparam logic [SYM_W-1:0] SYM_M = 3'd6;

  // Result error codes.
  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_CHAR   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_SUB_REPEAT = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_PAIR   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_REPEAT_VLD = 3'd4;
  localparam logic [ERR_W-1:0] ERR_OVER_THREE = 3'd5;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] code;
  } sym_dec_t;

  function automatic sym_dec_t decode_symbol(logic [CHAR_W-1:0] c);
    sym_dec_t d;
    d.ok   = 1'b1;
    d.code = SYM_I;
    case (c)
      8'h49: d.code = SYM_I;
      8'h56: d.code = SYM_V;
      8'h58: d.code = SYM_X;
      8'h4C: d.code = SYM_L;
      8'h43: d.code = SYM_C;
      8'h44: d.code = SYM_D;
      8'h4D: d.code = SYM_M;
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [SVAL_W-1:0] sym_value(logic [SYM_W-1:0] s);
    logic [SVAL_W-1:0] v;
    case (s)
      SYM_I: v = SVAL_W'(1);
      SYM_V: v = SVAL_W'(5);
      SYM_X: v = SVAL_W'(10);
      SYM_L: v = SVAL_W'(50);
      SYM_C: v = SVAL_W'(100);
      SYM_D: v = SVAL_W'(500);
      SYM_M: v = SVAL_W'(1000);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [VALUE_W-1:0] sat_add(logic [VALUE_W-1:0] a,
                                                 logic [SVAL_W-1:0] b);
    logic [VALUE_W:0] sum;
    sum = {1'b0, a} + {{(VALUE_W+1-SVAL_W){1'b0}}, b};
    return sum[VALUE_W] ? TOTAL_MAX : sum[VALUE_W-1:0];
  endfunction

endpackage

// ===== hdl/rn2b_ifs.sv =====
// ----------------------------------------------------------------------------
// rn2b channel interfaces
// Valid/ready channels for numeral characters and for decoded results.
// ----------------------------------------------------------------------------
interface rn2b_sym_if;
  logic                         valid;
  logic                         ready;
  logic [rn2b_pkg::CHAR_W-1:0]  char_code;
  logic                         last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface rn2b_res_if;
  logic                          valid;
  logic                          ready;
  logic [rn2b_pkg::VALUE_W-1:0]  value;
  logic [rn2b_pkg::ERR_W-1:0]    error_code;

  modport source (output valid, output value, output error_code, input ready);
  modport sink   (input valid, input value, input error_code, output ready);
endinterface

// ===== hdl/roman_numeral_to_binary.sv =====
// ----------------------------------------------------------------------------
// roman_numeral_to_binary
// Decodes a Roman numeral streamed one ASCII character per request.
// ----------------------------------------------------------------------------
// Usage:
//   symbols carries one character per request (char_code, last_char).
//   results carries one request per numeral, issued for the character that
//   has last_char set: the decoded value, or 0 with a nonzero error_code.
//   Characters without last_char produce no result.
// Timing:
//   One character is taken every cycle while the input register is not held
//   by a waiting final character. A character is decoded and the total
//   updated while it sits in the input register, and its result is then
//   loaded into the output register, where it becomes visible.
// Stalls:
//   While results is stalled, the held result stays stable; characters that
//   do not end a numeral keep flowing, and only a second final character
//   waits in the input register until the output register is taken.
// Reset:
//   rst clears both registers' valid flags and the decoder state; after a
//   final character the state returns to its reset value for the next numeral.
// ----------------------------------------------------------------------------
module roman_numeral_to_binary (
  input logic         clk,
  input logic         rst,
  rn2b_sym_if.sink    symbols,
  rn2b_res_if.source  results
);

  // Input register.
  logic                             in_vld;
  logic [rn2b_pkg::CHAR_W-1:0]      in_char;
  logic                             in_last;

  // Decoder state.
  logic [rn2b_pkg::SYM_W-1:0]       pend_sym;
  logic                             pend_vld;
  logic [rn2b_pkg::RUN_W-1:0]       run_count;
  logic [rn2b_pkg::VALUE_W-1:0]     total;
  logic                             bad_char;
  logic [rn2b_pkg::ERR_W-1:0]       order_err;

  logic [rn2b_pkg::SYM_W-1:0]       pend_sym_next;
  logic                             pend_vld_next;
  logic [rn2b_pkg::RUN_W-1:0]       run_count_next;
  logic [rn2b_pkg::VALUE_W-1:0]     total_next;
  logic                             bad_char_next;
  logic [rn2b_pkg::ERR_W-1:0]       order_err_next;

  // Output register.
  logic                             out_vld;
  logic [rn2b_pkg::VALUE_W-1:0]     out_value;
  logic [rn2b_pkg::ERR_W-1:0]       out_err;

  rn2b_pkg::sym_dec_t               dec;
  logic [rn2b_pkg::SVAL_W-1:0]      add_step;
  logic [rn2b_pkg::SVAL_W-1:0]      add_final;
  logic [rn2b_pkg::VALUE_W-1:0]     total_final;
  logic [rn2b_pkg::ERR_W-1:0]       res_err;
  logic [rn2b_pkg::VALUE_W-1:0]     res_value;
  logic                             pair_ok;
  logic                             advance;

  // A character without a result never waits; a final one needs room.
  assign advance       = in_vld && (!in_last || !out_vld || results.ready);
  assign symbols.ready = !in_vld || advance;

  assign results.valid      = out_vld;
  assign results.value      = out_value;
  assign results.error_code = out_err;

  always_comb begin
    dec            = rn2b_pkg::decode_symbol(in_char);
    pend_sym_next  = pend_sym;
    pend_vld_next  = pend_vld;
    run_count_next = run_count;
    bad_char_next  = bad_char;
    order_err_next = order_err;
    add_step       = '0;
    pair_ok        = !pend_sym[0] &&
                     (({1'b0, dec.code} == {1'b0, pend_sym} + 4'd1) ||
                      ({1'b0, dec.code} == {1'b0, pend_sym} + 4'd2));

    if (!dec.ok) begin
      bad_char_next = 1'b1;
    end else if (!pend_vld) begin
      pend_sym_next = dec.code;
      pend_vld_next = 1'b1;
    end else if (pend_sym < dec.code) begin
      // Subtractive pair consumes both symbols.
      if (order_err == rn2b_pkg::ERR_NONE) begin
        if (run_count > rn2b_pkg::RUN_INIT) begin
          order_err_next = rn2b_pkg::ERR_SUB_REPEAT;
        end else if (!pair_ok) begin
          order_err_next = rn2b_pkg::ERR_BAD_PAIR;
        end
      end
      add_step       = rn2b_pkg::sym_value(dec.code) - rn2b_pkg::sym_value(pend_sym);
      run_count_next = rn2b_pkg::RUN_INIT;
      pend_vld_next  = 1'b0;
    end else begin
      add_step = rn2b_pkg::sym_value(pend_sym);
      if (pend_sym == dec.code) begin
        if (run_count != rn2b_pkg::RUN_MAX) begin
          run_count_next = run_count + rn2b_pkg::RUN_W'(1);
        end
        if (order_err == rn2b_pkg::ERR_NONE) begin
          if (pend_sym[0]) begin
            order_err_next = rn2b_pkg::ERR_REPEAT_VLD;
          end else if (run_count_next > rn2b_pkg::RUN_LIMIT) begin
            order_err_next = rn2b_pkg::ERR_OVER_THREE;
          end
        end
      end else begin
        run_count_next = rn2b_pkg::RUN_INIT;
      end
      pend_sym_next = dec.code;
      pend_vld_next = 1'b1;
    end

    total_next  = rn2b_pkg::sat_add(total, add_step);
    add_final   = pend_vld_next ? rn2b_pkg::sym_value(pend_sym_next) : '0;
    total_final = rn2b_pkg::sat_add(total_next, add_final);
    res_err     = bad_char_next ? rn2b_pkg::ERR_BAD_CHAR : order_err_next;
    res_value   = (res_err == rn2b_pkg::ERR_NONE) ? total_final : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (symbols.ready) begin
      in_vld <= symbols.valid;
    end
    if (symbols.valid && symbols.ready) begin
      in_char <= symbols.char_code;
      in_last <= symbols.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && in_last)) begin
      pend_sym  <= rn2b_pkg::SYM_I;
      pend_vld  <= 1'b0;
      run_count <= rn2b_pkg::RUN_INIT;
      total     <= '0;
      bad_char  <= 1'b0;
      order_err <= rn2b_pkg::ERR_NONE;
    end else if (advance) begin
      pend_sym  <= pend_sym_next;
      pend_vld  <= pend_vld_next;
      run_count <= run_count_next;
      total     <= total_next;
      bad_char  <= bad_char_next;
      order_err <= order_err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance && in_last) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
    if (advance && in_last) begin
      out_value <= res_value;
      out_err   <= res_err;
    end
  end

endmodule

// ===== hdl/rn2b_checker.sv =====
// ----------------------------------------------------------------------------
// rn2b_checker
// Port-level checks on the result channel of the Roman numeral decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rn2b_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [rn2b_pkg::VALUE_W-1:0]  res_value,
  input logic [rn2b_pkg::ERR_W-1:0]    res_error_code
);

  // Only defined error codes ever leave the block.
  `ASSERT_IMPLY(a_err_range, clk, rst, res_valid, res_error_code <= rn2b_pkg::ERR_OVER_THREE)

  // A failed numeral always reports a zero value.
  `ASSERT_IMPLY(a_err_zero, clk, rst, res_valid && (res_error_code != rn2b_pkg::ERR_NONE),
                res_value == '0)

  // A stalled result holds until it is taken.
  `ASSERT_NEXT(a_stall_hold, clk, rst, res_valid && !res_ready,
               res_valid && $stable(res_value) && $stable(res_error_code))

  // Reset empties the output register.
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !res_valid)

endmodule

bind roman_numeral_to_binary rn2b_checker u_rn2b_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .res_value      (results.value),
  .res_error_code (results.error_code)
);
